FILE: hdl/ipv4hb_pkg.sv
// ---------------------------------------------------------------------------
// IPv4 header builder package
// Shared types and fixed header constants for the header builder blocks.
// ---------------------------------------------------------------------------
package ipv4hb_pkg;

    // Number of bytes in a header without options.
    localparam int HEADER_BYTES = 20;
    // Width of the byte position counter.
    localparam int BYTE_CNT_W = $clog2(HEADER_BYTES);

    // Largest payload that keeps the total length within 16 bits.
    localparam logic [15:0] MAX_PAYLOAD = 16'd65515;
    // Header length added to the payload length.
    localparam logic [15:0] HDR_LEN = 16'd20;
    // Version 4 and a header length of five words.
    localparam logic [7:0] VER_IHL = 8'h45;
    // Type of service byte.
    localparam logic [7:0] TOS = 8'h00;
    // Fixed identification word.
    localparam logic [15:0] IDENT = 16'h0001;
    // Flags and fragment offset word.
    localparam logic [15:0] FRAG = 16'h0000;
    // Limited broadcast address.
    localparam logic [31:0] BCAST_ADDR = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SRC = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TTL = 2'd1;
    localparam logic [7:0] TTL_RESET = 8'd64;

    // One send request.
    typedef struct packed {
        logic [31:0] dest_address;
        logic [7:0]  protocol;
        logic [15:0] payload_length;
    } t_request;

    // One header byte.
    typedef struct packed {
        logic [7:0] header_byte;
        logic       last;
        logic       is_broadcast;
    } t_result;

    // A fully prepared header waiting to be serialised.
    typedef struct packed {
        logic [15:0] total_length;
        logic [7:0]  time_to_live;
        logic [7:0]  protocol;
        logic [15:0] checksum;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic        is_broadcast;
    } t_header;

endpackage

FILE: hdl/ipv4hb_front.sv
// ---------------------------------------------------------------------------
// IPv4 header builder front end
// Accepts requests, fixes the total length and computes the header checksum
// over two register stages before handing the header to the queue.
// ---------------------------------------------------------------------------
module ipv4hb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  ipv4hb_pkg::t_request i_request,
    input  logic [31:0]         i_source_address,
    input  logic [7:0]          i_time_to_live,
    input  logic                i_full,
    output logic                o_push,
    output ipv4hb_pkg::t_header o_entry
);

    // Stage A registers.
    logic        r_a_valid;
    logic [15:0] r_a_total;
    logic [17:0] r_a_psum;
    logic [7:0]  r_a_ttl;
    logic [7:0]  r_a_proto;
    logic [31:0] r_a_src;
    logic [31:0] r_a_dst;
    logic        r_a_bcast;

    // Stage B registers.
    logic                r_b_valid;
    ipv4hb_pkg::t_header r_b_entry;

    logic        a_ready;
    logic        b_ready;
    logic        accept;
    logic [15:0] n_plen;
    logic [15:0] n_total;
    logic [17:0] n_psum;
    logic [18:0] n_sum;
    logic [16:0] n_fold1;
    logic [15:0] n_fold2;

    // Flow control: each stage moves on when the one behind it has room.
    assign b_ready = !r_b_valid || !i_full;
    assign a_ready = !r_a_valid || b_ready;
    assign o_busy  = !a_ready;
    assign accept  = i_start && a_ready;
    assign o_push  = r_b_valid && !i_full;
    assign o_entry = r_b_entry;

    // Length saturation and the first half of the checksum sum.
    always_comb begin
        n_plen  = (i_request.payload_length > ipv4hb_pkg::MAX_PAYLOAD) ?
                  ipv4hb_pkg::MAX_PAYLOAD : i_request.payload_length;
        n_total = n_plen + ipv4hb_pkg::HDR_LEN;
        n_psum  = 18'({ipv4hb_pkg::VER_IHL, ipv4hb_pkg::TOS})
                + 18'(ipv4hb_pkg::IDENT)
                + 18'(ipv4hb_pkg::FRAG)
                + 18'({i_time_to_live, i_request.protocol})
                + 18'(i_source_address[31:16])
                + 18'(i_source_address[15:0]);
    end

    // Second half of the sum, end-around carry folding and complement.
    always_comb begin
        n_sum   = 19'(r_a_psum) + 19'(r_a_total)
                + 19'(r_a_dst[31:16]) + 19'(r_a_dst[15:0]);
        n_fold1 = 17'(n_sum[15:0]) + 17'(n_sum[18:16]);
        n_fold2 = n_fold1[15:0] + 16'(n_fold1[16]);
    end

    // Stage A control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_start;
        end
    end

    // Stage A payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_total <= n_total;
            r_a_psum  <= n_psum;
            r_a_ttl   <= i_time_to_live;
            r_a_proto <= i_request.protocol;
            r_a_src   <= i_source_address;
            r_a_dst   <= i_request.dest_address;
            r_a_bcast <= (i_request.dest_address == ipv4hb_pkg::BCAST_ADDR);
        end
    end

    // Stage B control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    // Stage B payload: the finished header.
    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_entry.total_length   <= r_a_total;
            r_b_entry.time_to_live   <= r_a_ttl;
            r_b_entry.protocol       <= r_a_proto;
            r_b_entry.checksum       <= ~n_fold2;
            r_b_entry.source_address <= r_a_src;
            r_b_entry.dest_address   <= r_a_dst;
            r_b_entry.is_broadcast   <= r_a_bcast;
        end
    end

endmodule

FILE: hdl/ipv4hb_queue.sv
// ---------------------------------------------------------------------------
// IPv4 header builder queue
// Short first-in first-out store of prepared headers between the front end
// and the serialiser.
// ---------------------------------------------------------------------------
module ipv4hb_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ipv4hb_pkg::t_header i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output ipv4hb_pkg::t_header o_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ipv4hb_pkg::t_header r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/ipv4hb_back.sv
// ---------------------------------------------------------------------------
// IPv4 header builder serialiser
// Sends each prepared header one byte per cycle in network byte order,
// moving straight on to the next queued header after the last byte.
// ---------------------------------------------------------------------------
module ipv4hb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ipv4hb_pkg::t_header i_entry,
    output logic                o_pop,
    output logic                o_strobe,
    output ipv4hb_pkg::t_result o_result
);

    localparam int CW = ipv4hb_pkg::BYTE_CNT_W;
    localparam logic [CW-1:0] LAST_POS = CW'(ipv4hb_pkg::HEADER_BYTES - 1);

    logic                r_active;
    logic [CW-1:0]       r_cnt;
    ipv4hb_pkg::t_header r_cur;
    logic                r_strobe;
    ipv4hb_pkg::t_result r_result;
    logic [7:0]          n_byte;
    logic                at_last;

    assign at_last  = (r_cnt == LAST_POS);
    // A new header is taken when idle or while the last byte goes out.
    assign o_pop    = i_valid && (!r_active || at_last);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Byte selection by position in the header.
    always_comb begin
        case (r_cnt)
            5'd0:    n_byte = ipv4hb_pkg::VER_IHL;
            5'd1:    n_byte = ipv4hb_pkg::TOS;
            5'd2:    n_byte = r_cur.total_length[15:8];
            5'd3:    n_byte = r_cur.total_length[7:0];
            5'd4:    n_byte = ipv4hb_pkg::IDENT[15:8];
            5'd5:    n_byte = ipv4hb_pkg::IDENT[7:0];
            5'd6:    n_byte = ipv4hb_pkg::FRAG[15:8];
            5'd7:    n_byte = ipv4hb_pkg::FRAG[7:0];
            5'd8:    n_byte = r_cur.time_to_live;
            5'd9:    n_byte = r_cur.protocol;
            5'd10:   n_byte = r_cur.checksum[15:8];
            5'd11:   n_byte = r_cur.checksum[7:0];
            5'd12:   n_byte = r_cur.source_address[31:24];
            5'd13:   n_byte = r_cur.source_address[23:16];
            5'd14:   n_byte = r_cur.source_address[15:8];
            5'd15:   n_byte = r_cur.source_address[7:0];
            5'd16:   n_byte = r_cur.dest_address[31:24];
            5'd17:   n_byte = r_cur.dest_address[23:16];
            5'd18:   n_byte = r_cur.dest_address[15:8];
            5'd19:   n_byte = r_cur.dest_address[7:0];
            default: n_byte = 8'h00;
        endcase
    end

    // Sequencing of byte positions and headers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (r_active && at_last) begin
                r_active <= 1'b0;
                r_cnt    <= '0;
            end else if (r_active) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Current header and the output register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
        if (r_active) begin
            r_result.header_byte  <= n_byte;
            r_result.last         <= at_last;
            r_result.is_broadcast <= r_cur.is_broadcast;
        end
    end

endmodule

FILE: hdl/ipv4_header_builder_unit.sv
// ---------------------------------------------------------------------------
// IPv4 header builder
// Builds the 20-byte IPv4 header with its Internet checksum for each send
// request and delivers it one byte per cycle.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  request   in         start, busy            i_request (t_request)
//  result    out        o_strobe (no stall)    o_result (t_result)
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  Each request produces twenty result transfers on consecutive cycles.
//  In steady state the request rate is set by the byte-wide serialiser;
//  the first byte passes stages A and B, the queue and the serialiser registers.
//  The front end and the header queue keep accepting while bytes go out.
//  Synchronous active-low reset empties the pipeline and the queue, sets
//  the source address to zero and the TTL to 64.
// ---------------------------------------------------------------------------
module ipv4_header_builder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  ipv4hb_pkg::t_request                  i_request,
    output logic                                  o_strobe,
    output ipv4hb_pkg::t_result                   o_result,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ipv4hb_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [31:0]                           i_cfg_data
);

    logic [31:0]         r_source_address;
    logic [7:0]          r_time_to_live;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    ipv4hb_pkg::t_header q_wr_entry;
    ipv4hb_pkg::t_header q_rd_entry;

    // Configuration registers; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_address <= '0;
            r_time_to_live   <= ipv4hb_pkg::TTL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ipv4hb_pkg::CFG_IDX_SRC: r_source_address <= i_cfg_data;
                ipv4hb_pkg::CFG_IDX_TTL: r_time_to_live   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Request intake and checksum.
    ipv4hb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_request        (i_request),
        .i_source_address (r_source_address),
        .i_time_to_live   (r_time_to_live),
        .i_full           (q_full),
        .o_push           (q_push),
        .o_entry          (q_wr_entry)
    );

    // Header queue.
    ipv4hb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_rd_entry)
    );

    // Byte serialiser.
    ipv4hb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (q_rd_entry),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

`ifndef SYNTH
    // No transfer follows a reset cycle.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe after reset");

    // A header is never broken: each non-final byte is followed by another.
    a_header_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=>
            (o_strobe && (o_result.is_broadcast == $past(o_result.is_broadcast))))
        else $error("header interrupted or broadcast flag changed");

    // A header that follows directly on another starts with the version byte.
    a_next_header_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) ##1 o_strobe |->
            (o_result.header_byte == ipv4hb_pkg::VER_IHL))
        else $error("header does not start with version byte");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IPv4 header builder testbench
// Drives send requests and register writes into the header builder. Every
// header byte that comes out is checked against an independent prediction of
// the header, including its ones-complement checksum. The bench first runs a
// table of directed requests across several register settings, then random
// requests with idle bursts on the request side in all but the last phase.
// ---------------------------------------------------------------------------
module tb;

    // Cycles to let pass once the last expected byte has arrived.
    localparam int SETTLE_CYCLES = 8;
    // Cycles with no transfer on any channel before the run is abandoned.
    localparam int QUIET_LIMIT = 200;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_REQUESTS = 22;
    localparam int DIRECTED_ROWS = 22;

    // Indexes past the end of the register map. Writes to them are ignored.
    localparam logic [ipv4hb_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [ipv4hb_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    // Fixed header words and limits, as the protocol defines them.
    localparam logic [15:0] WORD_VER_TOS = 16'h4500;
    localparam logic [15:0] WORD_IDENT = 16'h0001;
    localparam logic [15:0] WORD_FRAG = 16'h0000;
    localparam logic [15:0] HEADER_LEN = 16'd20;
    localparam logic [15:0] PAYLOAD_CEILING = 16'd65515;
    localparam logic [31:0] LIMITED_BCAST = 32'hFFFF_FFFF;
    localparam logic [7:0] TTL_AFTER_RESET = 8'd64;

    // One directed request. Where typed is set, the total length, checksum
    // and broadcast flag are given by hand rather than predicted.
    typedef struct packed {
        ipv4hb_pkg::t_request req;
        logic                 typed;
        logic [15:0]          hdr_total;
        logic [15:0]          csum;
        logic                 bcast;
    } t_directed_row;

    // Rows 0 to 7 run straight after reset, with source 0.0.0.0 and TTL 64.
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        '{'{32'h0000_0000, 8'h00, 16'd0},     1'b1, 16'h0014, 16'h7AEA, 1'b0},
        '{'{32'hFFFF_FFFF, 8'hFF, 16'd65535}, 1'b1, 16'hFFFF, 16'h79FF, 1'b1},
        '{'{32'h0000_0000, 8'h00, 16'd65515}, 1'b1, 16'hFFFF, 16'h7AFE, 1'b0},
        '{'{32'h0000_0000, 8'h00, 16'd65516}, 1'b1, 16'hFFFF, 16'h7AFE, 1'b0},
        '{'{32'hFFFF_FFFE, 8'h11, 16'd8},     1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'h7FFF_FFFF, 8'h06, 16'd1460},  1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'hFFFF_FFFF, 8'h01, 16'd64},    1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'h0A00_0001, 8'h80, 16'h5555},  1'b0, 16'h0, 16'h0, 1'b0},
        // Rows 8 to 13: source 255.255.255.255 and TTL 255.
        '{'{32'hFFFF_FFFF, 8'hFF, 16'd65535}, 1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'h0000_0000, 8'h00, 16'd0},     1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'hFFFF_FFFF, 8'h00, 16'd65515}, 1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'h8000_0000, 8'h7F, 16'hAAAA},  1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'hC0A8_0101, 8'h11, 16'd65534}, 1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'h5555_AAAA, 8'hAA, 16'd1},     1'b0, 16'h0, 16'h0, 1'b0},
        // Rows 14 to 17: after writes to unused indexes, nothing has changed.
        '{'{32'h0102_0304, 8'h06, 16'd40},    1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'hFFFF_FFFF, 8'h11, 16'd512},   1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'hAAAA_5555, 8'h55, 16'd65516}, 1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'hFFFF_FF00, 8'h01, 16'd1000},  1'b0, 16'h0, 16'h0, 1'b0},
        // Rows 18 to 21: source 0.0.0.0 and TTL 0.
        '{'{32'h0000_0000, 8'h00, 16'd0},     1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'hFFFF_FFFF, 8'hFF, 16'd65535}, 1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'h0000_FFFF, 8'h32, 16'd65515}, 1'b0, 16'h0, 16'h0, 1'b0},
        '{'{32'hFFFF_0000, 8'h2F, 16'd576},   1'b0, 16'h0, 16'h0, 1'b0}
    };

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    ipv4hb_pkg::t_request                i_request = '0;
    logic                                o_strobe;
    ipv4hb_pkg::t_result                 o_result;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [ipv4hb_pkg::CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [31:0]                         i_cfg_data = '0;

    // Bench copy of the two registers.
    logic [31:0] model_src_addr = '0;
    logic [7:0]  model_ttl = TTL_AFTER_RESET;

    ipv4hb_pkg::t_result pending_bytes[$];
    int unsigned         error_count = 0;
    int unsigned         quiet_cycles = 0;
    bit                  idling_on = 1'b1;

    ipv4_header_builder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_request   (i_request),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Lay out one header in transmission order and queue its twenty bytes.
    task automatic queue_header(input ipv4hb_pkg::t_request req,
                                input logic [15:0] hdr_total,
                                input logic [15:0] csum, input logic bcast);
        logic [15:0]         words [10];
        ipv4hb_pkg::t_result hdr_byte;
        words[0] = WORD_VER_TOS;
        words[1] = hdr_total;
        words[2] = WORD_IDENT;
        words[3] = WORD_FRAG;
        words[4] = {model_ttl, req.protocol};
        words[5] = csum;
        words[6] = model_src_addr[31:16];
        words[7] = model_src_addr[15:0];
        words[8] = req.dest_address[31:16];
        words[9] = req.dest_address[15:0];
        for (int i = 0; i < ipv4hb_pkg::HEADER_BYTES; i++) begin
            hdr_byte.header_byte = (i % 2 == 0) ? words[i / 2][15:8] : words[i / 2][7:0];
            hdr_byte.last = (i == ipv4hb_pkg::HEADER_BYTES - 1);
            hdr_byte.is_broadcast = bcast;
            pending_bytes.push_back(hdr_byte);
        end
    endtask

    // Work out the total length and the header checksum, then queue the bytes.
    task automatic predict_header(input ipv4hb_pkg::t_request req);
        logic [15:0] plen;
        logic [15:0] hdr_total;
        logic [31:0] sum;
        plen = (req.payload_length > PAYLOAD_CEILING) ? PAYLOAD_CEILING
                                                      : req.payload_length;
        hdr_total = plen + HEADER_LEN;
        // The checksum word itself counts as zero in the sum.
        sum = WORD_VER_TOS + hdr_total + WORD_IDENT + WORD_FRAG
            + {model_ttl, req.protocol}
            + model_src_addr[31:16] + model_src_addr[15:0]
            + req.dest_address[31:16] + req.dest_address[15:0];
        // Fold the carries back in until the sum fits sixteen bits.
        while (sum[31:16] != 0)
            sum = sum[15:0] + sum[31:16];
        queue_header(req, hdr_total, ~sum[15:0], req.dest_address == LIMITED_BCAST);
    endtask

    // Present a request, after an optional idle burst, and wait for its
    // transfer. Start is left high so that a following request follows on.
    task automatic send_request(input ipv4hb_pkg::t_request req);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_request <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Write one register and mirror the write in the bench copy.
    task automatic write_register(input logic [ipv4hb_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (index)
            ipv4hb_pkg::CFG_IDX_SRC: model_src_addr = data;
            ipv4hb_pkg::CFG_IDX_TTL: model_ttl = data[7:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Let every expected byte arrive, then allow the pipeline to empty.
    task automatic drain();
        start <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_rows(input int first, input int last_row);
        for (int r = first; r <= last_row; r++) begin
            send_request(DIRECTED[r].req);
            if (DIRECTED[r].typed)
                queue_header(DIRECTED[r].req, DIRECTED[r].hdr_total,
                             DIRECTED[r].csum, DIRECTED[r].bcast);
            else
                predict_header(DIRECTED[r].req);
        end
    endtask

    // Random request, weighted towards broadcast, zero and the length limit.
    function automatic ipv4hb_pkg::t_request random_request();
        ipv4hb_pkg::t_request req;
        case ($urandom_range(0, 7))
            0: req.dest_address = LIMITED_BCAST;
            1: req.dest_address = '0;
            default: req.dest_address = $urandom;
        endcase
        req.protocol = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: req.payload_length = 16'($urandom_range(65505, 65535));
            1: req.payload_length = 16'($urandom_range(0, 65535));
            default: req.payload_length = 16'($urandom_range(0, 1500));
        endcase
        return req;
    endfunction

    // Stimulus sequence.
    initial begin
        ipv4hb_pkg::t_request req;
        logic [31:0] src;
        logic [31:0] ttl;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_rows(0, 7);
        drain();
        write_register(ipv4hb_pkg::CFG_IDX_SRC, 32'hFFFF_FFFF);
        write_register(ipv4hb_pkg::CFG_IDX_TTL, 32'h0000_00FF);
        run_rows(8, 13);
        drain();
        write_register(CFG_IDX_SPARE_A, $urandom);
        write_register(CFG_IDX_SPARE_B, 32'hFFFF_FFFF);
        run_rows(14, 17);
        drain();
        write_register(ipv4hb_pkg::CFG_IDX_SRC, 32'h0000_0000);
        // Upper data bits must not reach the TTL.
        write_register(ipv4hb_pkg::CFG_IDX_TTL, 32'hFFFF_FF00);
        run_rows(18, DIRECTED_ROWS - 1);

        // Random phases, each under a fresh register setting. The last one
        // runs back to back with no idle cycles.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            case ($urandom_range(0, 3))
                0: src = '0;
                1: src = 32'hFFFF_FFFF;
                default: src = $urandom;
            endcase
            ttl = (p == 0) ? 32'd1 : $urandom;
            write_register(ipv4hb_pkg::CFG_IDX_SRC, src);
            write_register(ipv4hb_pkg::CFG_IDX_TTL, ttl);
            idling_on = (p != RANDOM_PHASES - 1);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                req = random_request();
                send_request(req);
                predict_header(req);
            end
        end
        drain();

        if (error_count == 0)
            $display("PASS ipv4_header_builder_unit");
        else
            $display("FAIL ipv4_header_builder_unit");
        $finish;
    end

    // Compare each result transfer with the oldest expected byte.
    always @(posedge i_clk) begin
        ipv4hb_pkg::t_result want;
        if (i_rst_n) begin
            if ($isunknown(o_strobe)) begin
                error_count++;
                $display("%0t: result strobe expected 0 or 1, actual %b",
                         $realtime, o_strobe);
            end else if (o_strobe) begin
                if (pending_bytes.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected byte, expected none, actual %h",
                             $realtime, o_result);
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_result.header_byte !== want.header_byte) begin
                        error_count++;
                        $display("%0t: header_byte expected %h actual %h",
                                 $realtime, want.header_byte, o_result.header_byte);
                    end
                    if (o_result.last !== want.last) begin
                        error_count++;
                        $display("%0t: last expected %b actual %b",
                                 $realtime, want.last, o_result.last);
                    end
                    if (o_result.is_broadcast !== want.is_broadcast) begin
                        error_count++;
                        $display("%0t: is_broadcast expected %b actual %b",
                                 $realtime, want.is_broadcast, o_result.is_broadcast);
                    end
                end
            end
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL ipv4_header_builder_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
